// ===== src/arx_model_filter_defines.svh =====
// Assertion macros for the ARX model filter.
// Expects aclk and aresetn in the scope where the macros are used.
`ifndef ARX_MODEL_FILTER_DEFINES_SVH
`define ARX_MODEL_FILTER_DEFINES_SVH

// Same-cycle implication, checked out of reset only
`define ARX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("arx_model_filter: assertion failed");

// Next-cycle implication, checked out of reset only
`define ARX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("arx_model_filter: assertion failed");

`endif

// ===== src/arx_pkg.sv =====
// Shared types and fixed constants for the ARX model filter.
// No dependencies.
`default_nettype none

package arx_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int COEF_FRAC  = 14;
    localparam int DT_WIDTH   = 4;
    localparam int DT_MAX     = (1 << DT_WIDTH) - 1;

    localparam logic signed [COEF_WIDTH-1:0] FF_COEF0_RESET = 16'sd16384;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic vld;
        logic sub;
    } mac_ctl_t;

endpackage

`default_nettype wire

// ===== src/arx_hist.sv =====
// Input delay line of the ARX model filter: circular buffer memory with
// per-entry valid bits and a registered read port. Uses arx_pkg.
`default_nettype none

module arx_hist
    import arx_pkg::*;
#(
    parameter int AW = 4,
    parameter int SW = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 wr_en,
    input  wire logic signed [SW-1:0] wr_data,
    input  wire logic [AW-1:0]        rd_off,
    output logic signed [SW-1:0]      rd_data
);

    localparam int MEM_DEPTH = 1 << AW;

    logic signed [SW-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_reg;
    logic [AW-1:0]        newest_reg;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic signed [SW-1:0] rd_data_reg;
    logic                 rd_vld_reg;

    assign wr_addr = newest_reg + AW'(1);
    // Sample k back lives k entries behind the newest one
    assign rd_addr = newest_reg - rd_off;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            newest_reg <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= vld_reg[rd_addr];
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
                newest_reg       <= wr_addr;
            end
        end
    end

    // Never-written entries read as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== src/arx_mac.sv =====
// Shared multiply-accumulate unit of the ARX model filter: registered
// product followed by a signed add or subtract into the accumulator. Uses arx_pkg.
`default_nettype none

module arx_mac
    import arx_pkg::*;
#(
    parameter int SW    = 16,
    parameter int ACC_W = 36
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire mac_ctl_t                     ctl,
    input  wire logic signed [SW-1:0]         op_a,
    input  wire logic signed [COEF_WIDTH-1:0] coef,
    output logic signed [ACC_W-1:0]           acc,
    output logic                              busy
);

    localparam int PROD_W = SW + COEF_WIDTH;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     p_vld_reg;
    logic                     p_sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;

    always_ff @(posedge aclk) begin
        prod_reg  <= op_a * coef;
        p_sub_reg <= ctl.sub;
    end

    assign prod_ext = ACC_W'(prod_reg);

    always_comb begin
        acc_next = acc_reg;
        if (ctl.clr) begin
            acc_next = '0;
        end else if (p_vld_reg) begin
            acc_next = p_sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            acc_reg   <= '0;
        end else begin
            p_vld_reg <= ctl.vld;
            acc_reg   <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign busy = p_vld_reg;

endmodule

`default_nettype wire

// ===== src/arx_model_filter.sv =====
// ARX plant model: y = sum ff_coef[i]*x[i+dead_time] - sum fb_coef[j]*y[j], shifted
// right by 14 (floor) and saturated. One shared multiply-accumulate unit takes one
// term per cycle; for each item the sequencer issues each term in turn, drains the read,
// multiply and accumulate registers, saturates and stores the result, and then
// returns to idle, where the next sample is taken.
// The input channel is not ready meanwhile; a finished result waits in the output
// register while the next sample is taken, and a result still held there when the
// next one is finished stalls the store until it is taken.
// Configuration writes are always accepted.
`default_nettype none

`include "arx_model_filter_defines.svh"

module arx_model_filter
    import arx_pkg::*;
#(
    parameter int FF_TAPS       = 3,
    parameter int FB_TAPS       = 3,
    parameter int MAX_DEAD_TIME = 8,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          s_valid,
    output logic                                               s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]                s_sample_in,
    output logic                                               m_valid,
    input  wire logic                                          m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]                     m_sample_out,
    input  wire logic                                          cfg_valid,
    output logic                                               cfg_ready,
    input  wire logic [$clog2(FF_TAPS + FB_TAPS + 1)-1:0]      cfg_index,
    input  wire logic [COEF_WIDTH-1:0]                         cfg_data
);

    localparam int NTERMS   = FF_TAPS + FB_TAPS;
    localparam int TERM_W   = $clog2(NTERMS + 1);
    localparam int IDX_W    = $clog2(NTERMS);
    localparam int IN_DEPTH = FF_TAPS + MAX_DEAD_TIME;
    localparam int AW       = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int SW       = SAMPLE_WIDTH;
    localparam int ACC_W    = SW + COEF_WIDTH + IDX_W + 1;

    localparam logic [DT_WIDTH-1:0] DT_CLAMP =
        DT_WIDTH'((MAX_DEAD_TIME > DT_MAX) ? DT_MAX : MAX_DEAD_TIME);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [TERM_W-1:0]              term_reg, term_next;
    logic signed [COEF_WIDTH-1:0]   coef_reg [NTERMS];
    logic [DT_WIDTH-1:0]            dt_reg;
    logic signed [SW-1:0]           ohist_reg [FB_TAPS];
    logic                           m_valid_reg;
    logic signed [SW-1:0]           m_data_reg;

    // issue stage registers, aligned with the history read
    logic                           a_vld_reg;
    logic                           a_fb_reg;
    logic signed [COEF_WIDTH-1:0]   a_coef_reg;
    logic signed [SW-1:0]           a_fbop_reg;

    logic                           s_xfer;
    logic                           out_free;
    logic                           is_ff;
    logic [TERM_W-1:0]              fb_sel;
    logic signed [SW-1:0]           fb_op;
    logic [7:0]                     rd_off_w;
    logic signed [SW-1:0]           hist_data;
    logic signed [SW-1:0]           mac_op;
    mac_ctl_t                       mac_ctl;
    logic signed [ACC_W-1:0]        acc;
    logic                           mac_busy;
    logic signed [ACC_W-1:0]        shifted;
    logic signed [SW-1:0]           y_sat;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= FF_COEF0_RESET;
            for (int i = 1; i < NTERMS; i++) begin
                coef_reg[i] <= '0;
            end
            dt_reg      <= '0;
        end else if (cfg_valid) begin
            if (cfg_index < TERM_W'(NTERMS)) begin
                coef_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
            end else if (cfg_index == TERM_W'(NTERMS)) begin
                if (32'(cfg_data[DT_WIDTH-1:0]) > 32'(MAX_DEAD_TIME)) begin
                    dt_reg <= DT_CLAMP;
                end else begin
                    dt_reg <= cfg_data[DT_WIDTH-1:0];
                end
            end
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        unique case (state_reg)
            ST_IDLE: begin
                term_next = '0;
                if (s_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                term_next = term_reg + TERM_W'(1);
                if (term_reg == TERM_W'(NTERMS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!a_vld_reg && !mac_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            term_reg  <= '0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    // operand selection for the term being issued
    assign is_ff    = term_reg < TERM_W'(FF_TAPS);
    assign fb_sel   = term_reg - TERM_W'(FF_TAPS);
    assign rd_off_w = 8'(term_reg) + 8'(dt_reg);

    always_comb begin
        fb_op = '0;
        for (int j = 0; j < FB_TAPS; j++) begin
            if (fb_sel == TERM_W'(j)) begin
                fb_op = ohist_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_fb_reg   <= !is_ff;
        a_coef_reg <= coef_reg[term_reg[IDX_W-1:0]];
        a_fbop_reg <= fb_op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= (state_reg == ST_RUN);
        end
    end

    arx_hist #(
        .AW (AW),
        .SW (SW)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_xfer),
        .wr_data (s_sample_in),
        .rd_off  (rd_off_w[AW-1:0]),
        .rd_data (hist_data)
    );

    assign mac_op      = a_fb_reg ? a_fbop_reg : hist_data;
    assign mac_ctl.clr = s_xfer;
    assign mac_ctl.vld = a_vld_reg;
    assign mac_ctl.sub = a_fb_reg;

    arx_mac #(
        .SW    (SW),
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mac_op),
        .coef    (a_coef_reg),
        .acc     (acc),
        .busy    (mac_busy)
    );

    // floor shift, then clamp to the sample range
    assign shifted = acc >>> COEF_FRAC;

    always_comb begin
        if (shifted > SAT_HI) begin
            y_sat = SAT_HI[SW-1:0];
        end else if (shifted < SAT_LO) begin
            y_sat = SAT_LO[SW-1:0];
        end else begin
            y_sat = shifted[SW-1:0];
        end
    end

    wire finish_load = (state_reg == ST_FINISH) && out_free;

    // output history: advance on each new result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < FB_TAPS; j++) begin
                ohist_reg[j] <= '0;
            end
        end else if (finish_load) begin
            for (int j = FB_TAPS - 1; j > 0; j--) begin
                ohist_reg[j] <= ohist_reg[j - 1];
            end
            ohist_reg[0] <= y_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish_load) begin
            m_data_reg <= y_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;

    `ARX_ASSERT_NEXT(a_xfer_starts_run, s_valid && s_ready, state_reg == ST_RUN)
    `ARX_ASSERT_IMP(a_finish_pipe_empty, state_reg == ST_FINISH, !a_vld_reg && !mac_busy)
    `ARX_ASSERT_IMP(a_idle_no_issue, state_reg == ST_IDLE, !a_vld_reg && !mac_busy)
    `ARX_ASSERT_IMP(a_term_in_range, state_reg == ST_RUN, term_reg < TERM_W'(NTERMS))

endmodule

`default_nettype wire

// ===== sim/arx_tb_pkg.sv =====
// Register map of the ARX model filter as seen by the testbench.
// Shared by the response checker and the testbench top; no dependencies.
package arx_tb_pkg;

    typedef enum logic [2:0] {
        REG_FF0,
        REG_FF1,
        REG_FF2,
        REG_FB0,
        REG_FB1,
        REG_FB2,
        REG_DEAD_TIME,
        REG_UNUSED
    } arx_reg_e;

endpackage

// ===== sim/arx_response_check.sv =====
// Response checker for the ARX model filter: mirrors coefficient and dead-time
// writes, predicts each output sample and compares it with the result channel.
// Depends on arx_pkg and arx_tb_pkg.
module arx_response_check
    import arx_pkg::*;
    import arx_tb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_sample_in,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_sample_out,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FF_TAPS    = 3;
    localparam int FB_TAPS    = 3;
    localparam int MAX_DT     = 8;
    localparam int IN_DEPTH   = FF_TAPS + MAX_DT;
    localparam longint SAT_HI = 32767;
    localparam longint SAT_LO = -32768;

    logic signed [15:0] ff_coef [FF_TAPS];
    logic signed [15:0] fb_coef [FB_TAPS];
    logic [3:0]         dead_time;
    logic signed [15:0] in_hist [IN_DEPTH];
    logic signed [15:0] out_hist [FB_TAPS];
    logic signed [15:0] expected_outputs [$];

    // Shift the sample in, form the tap sums and return the saturated output
    function automatic logic signed [15:0] model_response(input logic signed [15:0] x);
        longint acc;
        longint y;
        for (int i = IN_DEPTH - 1; i > 0; i--) in_hist[i] = in_hist[i-1];
        in_hist[0] = x;
        acc = 0;
        for (int i = 0; i < FF_TAPS; i++)
            acc += longint'(ff_coef[i]) * longint'(in_hist[i + dead_time]);
        for (int j = 0; j < FB_TAPS; j++)
            acc -= longint'(fb_coef[j]) * longint'(out_hist[j]);
        // arithmetic shift floors negative sums
        y = acc >>> COEF_FRAC;
        if (y > SAT_HI) y = SAT_HI;
        else if (y < SAT_LO) y = SAT_LO;
        for (int j = FB_TAPS - 1; j > 0; j--) out_hist[j] = out_hist[j-1];
        out_hist[0] = 16'(y);
        return 16'(y);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        logic signed [15:0] predicted;
        if (!aresetn) begin
            foreach (ff_coef[i]) ff_coef[i] = '0;
            foreach (fb_coef[j]) fb_coef[j] = '0;
            ff_coef[0] = FF_COEF0_RESET;
            dead_time = '0;
            foreach (in_hist[i]) in_hist[i] = '0;
            foreach (out_hist[j]) out_hist[j] = '0;
            expected_outputs.delete();
            mismatches = 0;
        end else begin
            // retire the older result before queueing the new sample's
            if (m_valid && m_ready) begin
                if (expected_outputs.size() == 0) begin
                    flag_mismatch($sformatf("sample_out %0d with nothing pending",
                                            m_sample_out));
                end else begin
                    predicted = expected_outputs.pop_front();
                    if (m_sample_out !== predicted)
                        flag_mismatch($sformatf("sample_out %0d, predicted %0d",
                                                m_sample_out, predicted));
                end
            end
            if (s_valid && s_ready)
                expected_outputs.push_back(model_response(s_sample_in));
            if (cfg_valid && cfg_ready) begin
                case (arx_reg_e'(cfg_index))
                    REG_FF0, REG_FF1, REG_FF2: begin
                        ff_coef[cfg_index - REG_FF0] = cfg_data;
                    end
                    REG_FB0, REG_FB1, REG_FB2: begin
                        fb_coef[cfg_index - REG_FB0] = cfg_data;
                    end
                    REG_DEAD_TIME: begin
                        // clamp oversize dead times to the maximum dead time
                        dead_time = (cfg_data[3:0] > MAX_DT) ? 4'(MAX_DT) : cfg_data[3:0];
                    end
                    default: begin
                        // unmapped index: drop the write
                    end
                endcase
            end
        end
        outstanding = expected_outputs.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the ARX model filter: clock, reset, stimulus and verdict.
// Depends on arx_pkg, arx_tb_pkg, arx_response_check and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arx_pkg::*;
    import arx_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 120;

    localparam logic [15:0] OPENING [8] = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff,
                                            16'h8000, 16'h5555, 16'haaaa, 16'h0100};
    localparam logic [15:0] RAILS [6]   = '{16'h7fff, 16'h7fff, 16'h7fff,
                                            16'h8000, 16'h8000, 16'h8000};
    localparam logic [15:0] CORNER [4]  = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic signed [15:0]    s_sample_in = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic signed [15:0]    m_sample_out;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index   = '0;
    logic [COEF_WIDTH-1:0] cfg_data    = '0;

    int mismatches;
    int outstanding;
    int send_idle   = 20;
    int recv_idle   = 47;
    int cycle_count = 0;
    logic [15:0] reg_image [8];

    always #5 aclk = ~aclk;

    arx_model_filter uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    arx_response_check response_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [15:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) return CORNER[$urandom_range(3)];
        if (pick < 35) return 16'($urandom_range(512)) - 16'd256;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] random_coef(input int span);
        if ($urandom_range(4) == 0) return 16'($urandom);
        return 16'($urandom_range(2 * span) - span);
    endfunction

    // Entered and left at a falling edge; valid is left high on return
    task automatic put_sample(input logic [15:0] value);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_registers();
        for (int r = REG_FF0; r <= REG_UNUSED; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(r);
            cfg_data  <= reg_image[r];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] dt_word;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset coefficients pass the input straight through
        foreach (OPENING[i]) put_sample(OPENING[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results(12);
            send_idle = (ph < 4) ? 20 : (ph < 8) ? 47 : 0;
            recv_idle = (ph < 4) ? 47 : (ph < 8) ? 20 : 0;
            case (ph)
                0: begin
                    // largest coefficients, dead time code 15 clamps to the maximum
                    foreach (reg_image[r]) reg_image[r] = 16'h7fff;
                end
                1: begin
                    foreach (reg_image[r]) reg_image[r] = 16'h8000;
                    reg_image[REG_DEAD_TIME] = 16'h8009;
                end
                default: begin
                    for (int r = REG_FF0; r <= REG_FF2; r++) reg_image[r] = random_coef(12000);
                    for (int r = REG_FB0; r <= REG_FB2; r++) reg_image[r] = random_coef(5000);
                    dt_word = 16'($urandom);
                    dt_word[3:0] = (ph == 2) ? 4'd8 : (ph == 3) ? 4'd0 : 4'($urandom_range(15));
                    reg_image[REG_DEAD_TIME] = dt_word;
                    reg_image[REG_UNUSED]    = 16'($urandom);
                end
            endcase
            write_registers();

            if (ph < 2) foreach (RAILS[i]) put_sample(RAILS[i]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off until the pipeline is empty now and then
                if (n == PHASE_ITEMS / 2 && ph % 4 == 1) drain_results(0);
                put_sample(random_sample());
            end
        end

        drain_results(20);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== arx_model_filter.f =====
+incdir+src
src/arx_pkg.sv
src/arx_hist.sv
src/arx_mac.sv
src/arx_model_filter.sv
sim/arx_tb_pkg.sv
sim/arx_response_check.sv
sim/tb.sv
